[hdl/deadline_task_scheduler_assert.svh]
// Assertion macros used by the checker of the deadline scheduler.
// Each expects clk and rst_n in scope.
`ifndef DEADLINE_TASK_SCHEDULER_ASSERT_SVH
`define DEADLINE_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define DTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deadline scheduler check failed");

// Next-cycle implication.
`define DTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deadline scheduler check failed");

`endif

[hdl/dts_pkg.sv]
package dts_pkg;

    // Commands
    localparam logic [2:0] CMD_ADVANCE      = 3'd0;
    localparam logic [2:0] CMD_ARM_ONCE     = 3'd1;
    localparam logic [2:0] CMD_ARM_PERIODIC = 3'd2;
    localparam logic [2:0] CMD_BLOCK        = 3'd3;
    localparam logic [2:0] CMD_UNBLOCK      = 3'd4;
    localparam logic [2:0] CMD_RUN          = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_RUN     = 2'd0;
    localparam logic [1:0] KIND_SKIPPED = 2'd1;
    localparam logic [1:0] KIND_PARKED  = 2'd2;
    localparam logic [1:0] KIND_SLEEP   = 2'd3;

    // Slot places
    localparam logic [1:0] PLACE_IDLE   = 2'd0;
    localparam logic [1:0] PLACE_QUEUED = 2'd1;
    localparam logic [1:0] PLACE_PARKED = 2'd2;

    // Flag bit positions
    localparam int FLAG_PERIODIC = 0;
    localparam int FLAG_BLOCKED  = 1;
    localparam int FLAG_ENONLY   = 2;

    // Configuration register indexes
    localparam int         CFG_IDX_W          = 2;
    localparam logic [1:0] CFG_DEVICE_ENABLED = 2'd0;
    localparam logic [1:0] CFG_IDLE_WAIT      = 2'd1;

    localparam logic [31:0] IDLE_WAIT_RESET = 32'd1000;
    localparam logic [7:0]  ORDER_FULL      = 8'hFF;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] interval;
        logic [7:0]  order;
    } slot_rec_t;

    typedef struct packed {
        logic deadline;
        logic interval;
        logic order;
    } mem_wen_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] sleep_ms;
        logic        last;
    } result_t;

endpackage

[hdl/dts_slot_mem.sv]
module dts_slot_mem
    import dts_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output slot_rec_t     rd_data,
    input  logic [AW-1:0] wr_addr,
    input  mem_wen_t      wen,
    input  slot_rec_t     wr_data
);

    slot_rec_t mem [DEPTH];

    // Per-field write enables
    always_ff @(posedge clk)
    begin
        if (wen.deadline)
        begin
            mem[wr_addr].deadline <= wr_data.deadline;
        end
        if (wen.interval)
        begin
            mem[wr_addr].interval <= wr_data.interval;
        end
        if (wen.order)
        begin
            mem[wr_addr].order <= wr_data.order;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/dts_out_reg.sv]
module dts_out_reg
    import dts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t din,
    input  logic    ready,
    output logic    valid,
    output logic    can_load,
    output result_t dout
);

    logic valid_reg;

    assign can_load = !valid_reg || ready;
    assign valid    = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dout <= din;
        end
    end

endmodule

[hdl/deadline_task_scheduler.sv]
// Deadline scheduler over TASK_SLOTS task slots with a 32-bit ms clock.
// Input channel (in_valid/in_ready): one command per transaction; cmd,
// task_id, amount and enabled_only. Only a run command gives results.
// Output channel (out_valid/out_ready): one dispatch per transaction in
// deadline order, then a sleep report with last set. An output register
// holds the pending transaction, so the sequencer loads the next result as
// soon as the current one is taken.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 device
// enabled, index 1 idle wait; write only while idle.
// Advance, block and unblock are handled in idle; an arm passes through the
// order-number state S_GIVE before it returns to idle. A run sweeps the slot
// memory one entry a cycle through its single read port: unpark sweeps, a due
// sweep, dispatch sweeps and a sleep sweep. Handing out an order number when
// the counter is full first renumbers live slots.
// Reset: all slots idle, time zero, registers at their reset values; the
// slot memory needs no clearing. A stalled receiver holds the sequencer at
// its next result; no command is taken until the run completes.
module deadline_task_scheduler
    import dts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           cmd,
    input  logic [3:0]           task_id,
    input  logic [31:0]          amount,
    input  logic                 enabled_only,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [3:0]           slot,
    output logic [31:0]          sleep_ms,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(TASK_SLOTS);

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_GIVE     = 4'd1;
    localparam logic [3:0] S_RN_SCAN  = 4'd2;
    localparam logic [3:0] S_RN_WRITE = 4'd3;
    localparam logic [3:0] S_UP_SCAN  = 4'd4;
    localparam logic [3:0] S_UP_WRITE = 4'd5;
    localparam logic [3:0] S_DUE_SCAN = 4'd6;
    localparam logic [3:0] S_DS_SCAN  = 4'd7;
    localparam logic [3:0] S_DS_EMIT  = 4'd8;
    localparam logic [3:0] S_SL_SCAN  = 4'd9;
    localparam logic [3:0] S_SL_EMIT  = 4'd10;

    // Control state
    logic [3:0]            state_reg, state_next;
    logic [3:0]            ret_reg, ret_next;
    logic [31:0]           time_reg, time_next;
    logic [7:0]            ord_cnt_reg, ord_cnt_next;
    logic [CNT_W-1:0]      rn_cnt_reg, rn_cnt_next;
    logic [CNT_W-1:0]      sc_reg, sc_next;
    logic                  chk_v_reg, chk_v_next;
    logic                  bv_reg, bv_next;
    logic                  dev_en_reg;
    logic [31:0]           idle_wait_reg;
    logic [1:0]            place_reg [TASK_SLOTS];
    logic [1:0]            place_next [TASK_SLOTS];
    logic [2:0]            flags_reg [TASK_SLOTS];
    logic [2:0]            flags_next [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] due_reg, due_next;
    logic [TASK_SLOTS-1:0] done_reg, done_next;

    // Datapath registers
    logic [IDX_W-1:0]      tgt_reg, tgt_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [31:0]           best_dl_reg, best_dl_next;
    logic [31:0]           best_iv_reg, best_iv_next;
    logic [7:0]            best_ord_reg, best_ord_next;

    // Memory and output stage connections
    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    slot_rec_t             mem_rd_data;
    logic [IDX_W-1:0]      mem_wr_addr;
    mem_wen_t              mem_wen;
    slot_rec_t             mem_wdata;
    logic                  out_load;
    logic                  out_can_load;
    result_t               out_din;
    result_t               out_q;

    logic [IDX_W-1:0]      pf_idx;
    logic [1:0]            pf_place;
    logic [2:0]            pf_flags;
    logic [IDX_W-1:0]      tid;
    logic                  in_range;
    logic                  is_scan;
    logic                  scan_done;
    logic                  cand;
    logic                  better;
    logic [1:0]            disp_kind;

    dts_slot_mem #(
        .DEPTH (TASK_SLOTS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_addr (mem_wr_addr),
        .wen     (mem_wen),
        .wr_data (mem_wdata)
    );

    dts_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .din      (out_din),
        .ready    (out_ready),
        .valid    (out_valid),
        .can_load (out_can_load),
        .dout     (out_q)
    );

    assign kind     = out_q.kind;
    assign slot     = out_q.slot;
    assign sleep_ms = out_q.sleep_ms;
    assign last     = out_q.last;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign tid      = IDX_W'(task_id);
    assign in_range = (32'(task_id) < TASK_SLOTS);
    assign is_scan  = state_reg inside {S_RN_SCAN, S_UP_SCAN, S_DUE_SCAN, S_DS_SCAN, S_SL_SCAN};
    assign scan_done = !(sc_reg < N_CNT) && !chk_v_reg;

    // One read index into the slot place and flag arrays
    always_comb
    begin
        case (state_reg)
            S_IDLE:    pf_idx = tid;
            S_DS_EMIT: pf_idx = best_idx_reg;
            default:   pf_idx = chk_idx_reg;
        endcase
    end

    assign pf_place = place_reg[pf_idx];
    assign pf_flags = flags_reg[pf_idx];

    // Candidate qualification and ranking for the current sweep
    always_comb
    begin
        case (state_reg)
            S_RN_SCAN:
            begin
                cand   = (pf_place != PLACE_IDLE) && !done_reg[chk_idx_reg];
                better = !bv_reg || (mem_rd_data.order < best_ord_reg);
            end
            S_UP_SCAN:
            begin
                cand   = (pf_place == PLACE_PARKED) && !pf_flags[FLAG_BLOCKED];
                better = !bv_reg || (mem_rd_data.order < best_ord_reg);
            end
            S_DS_SCAN:
            begin
                cand   = due_reg[chk_idx_reg];
                better = !bv_reg || (mem_rd_data.deadline < best_dl_reg) ||
                         ((mem_rd_data.deadline == best_dl_reg) &&
                          (mem_rd_data.order < best_ord_reg));
            end
            S_SL_SCAN:
            begin
                cand   = (pf_place == PLACE_QUEUED);
                better = !bv_reg || (mem_rd_data.deadline < best_dl_reg);
            end
            default:
            begin
                cand   = 1'b0;
                better = 1'b0;
            end
        endcase
    end

    // Blocked wins, then the enabled-only gate
    always_comb
    begin
        if (pf_flags[FLAG_BLOCKED])
        begin
            disp_kind = KIND_PARKED;
        end
        else if (dev_en_reg || !pf_flags[FLAG_ENONLY])
        begin
            disp_kind = KIND_RUN;
        end
        else
        begin
            disp_kind = KIND_SKIPPED;
        end
    end

    always_comb
    begin
        logic scan_start;

        scan_start    = 1'b0;
        state_next    = state_reg;
        ret_next      = ret_reg;
        time_next     = time_reg;
        ord_cnt_next  = ord_cnt_reg;
        rn_cnt_next   = rn_cnt_reg;
        sc_next       = sc_reg;
        chk_v_next    = chk_v_reg;
        chk_idx_next  = chk_idx_reg;
        bv_next       = bv_reg;
        place_next    = place_reg;
        flags_next    = flags_reg;
        due_next      = due_reg;
        done_next     = done_reg;
        tgt_next      = tgt_reg;
        best_idx_next = best_idx_reg;
        best_dl_next  = best_dl_reg;
        best_iv_next  = best_iv_reg;
        best_ord_next = best_ord_reg;

        mem_rd_en   = 1'b0;
        mem_rd_addr = sc_reg[IDX_W-1:0];
        mem_wr_addr = tgt_reg;
        mem_wen     = '0;
        mem_wdata   = '{deadline: time_reg, interval: amount, order: ord_cnt_reg};
        out_load    = 1'b0;
        out_din     = '{kind: KIND_RUN, slot: 4'd0, sleep_ms: 32'd0, last: 1'b0};

        // Sweep: issue one read a cycle, judge the entry in the cycle after
        if (is_scan)
        begin
            if (sc_reg < N_CNT)
            begin
                mem_rd_en    = 1'b1;
                chk_v_next   = 1'b1;
                chk_idx_next = sc_reg[IDX_W-1:0];
                sc_next      = sc_reg + 1'b1;
            end
            else
            begin
                chk_v_next = 1'b0;
            end
            if (chk_v_reg && cand && better)
            begin
                bv_next       = 1'b1;
                best_idx_next = chk_idx_reg;
                best_dl_next  = mem_rd_data.deadline;
                best_iv_next  = mem_rd_data.interval;
                best_ord_next = mem_rd_data.order;
            end
            if (chk_v_reg && (state_reg == S_DUE_SCAN))
            begin
                due_next[chk_idx_reg] = (pf_place == PLACE_QUEUED) &&
                                        !(time_reg < mem_rd_data.deadline);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_ADVANCE:
                        begin
                            time_next = time_reg + amount;
                        end
                        CMD_ARM_ONCE, CMD_ARM_PERIODIC:
                        begin
                            if (in_range)
                            begin
                                flags_next[tid] = '0;
                                flags_next[tid][FLAG_BLOCKED]  = pf_flags[FLAG_BLOCKED];
                                flags_next[tid][FLAG_PERIODIC] = (cmd == CMD_ARM_PERIODIC);
                                flags_next[tid][FLAG_ENONLY]   = enabled_only;
                                place_next[tid]  = PLACE_QUEUED;
                                mem_wr_addr      = tid;
                                mem_wen.deadline = 1'b1;
                                if (cmd == CMD_ARM_PERIODIC)
                                begin
                                    mem_wen.interval = 1'b1;
                                end
                                else
                                begin
                                    mem_wdata.deadline = time_reg + amount;
                                end
                                tgt_next   = tid;
                                ret_next   = S_IDLE;
                                state_next = S_GIVE;
                            end
                        end
                        CMD_BLOCK:
                        begin
                            if (in_range && pf_flags[FLAG_PERIODIC])
                            begin
                                flags_next[tid][FLAG_BLOCKED] = 1'b1;
                            end
                        end
                        CMD_UNBLOCK:
                        begin
                            if (in_range)
                            begin
                                flags_next[tid][FLAG_BLOCKED] = 1'b0;
                            end
                        end
                        CMD_RUN:
                        begin
                            state_next = S_UP_SCAN;
                            scan_start = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_GIVE:
            begin
                // Renumber live slots before the counter would overflow
                if (ord_cnt_reg == ORDER_FULL)
                begin
                    done_next   = '0;
                    rn_cnt_next = '0;
                    state_next  = S_RN_SCAN;
                end
                else
                begin
                    mem_wr_addr     = tgt_reg;
                    mem_wen.order   = 1'b1;
                    mem_wdata.order = ord_cnt_reg;
                    ord_cnt_next    = ord_cnt_reg + 8'd1;
                    state_next      = ret_reg;
                end
                scan_start = 1'b1;
            end
            S_RN_SCAN:
            begin
                if (scan_done)
                begin
                    if (bv_reg)
                    begin
                        state_next = S_RN_WRITE;
                    end
                    else
                    begin
                        ord_cnt_next = 8'(rn_cnt_reg);
                        state_next   = S_GIVE;
                    end
                end
            end
            S_RN_WRITE:
            begin
                mem_wr_addr             = best_idx_reg;
                mem_wen.order           = 1'b1;
                mem_wdata.order         = 8'(rn_cnt_reg);
                done_next[best_idx_reg] = 1'b1;
                rn_cnt_next             = rn_cnt_reg + 1'b1;
                state_next              = S_RN_SCAN;
                scan_start              = 1'b1;
            end
            S_UP_SCAN:
            begin
                if (scan_done)
                begin
                    if (bv_reg)
                    begin
                        state_next = S_UP_WRITE;
                    end
                    else
                    begin
                        state_next = S_DUE_SCAN;
                        scan_start = 1'b1;
                    end
                end
            end
            S_UP_WRITE:
            begin
                mem_wr_addr              = best_idx_reg;
                mem_wen.deadline         = 1'b1;
                place_next[best_idx_reg] = PLACE_QUEUED;
                tgt_next                 = best_idx_reg;
                ret_next                 = S_UP_SCAN;
                state_next               = S_GIVE;
            end
            S_DUE_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_DS_SCAN;
                    scan_start = 1'b1;
                end
            end
            S_DS_SCAN:
            begin
                if (scan_done)
                begin
                    if (bv_reg)
                    begin
                        state_next = S_DS_EMIT;
                    end
                    else
                    begin
                        state_next = S_SL_SCAN;
                        scan_start = 1'b1;
                    end
                end
            end
            S_DS_EMIT:
            begin
                if (out_can_load)
                begin
                    out_load               = 1'b1;
                    out_din.kind           = disp_kind;
                    out_din.slot           = 4'(best_idx_reg);
                    due_next[best_idx_reg] = 1'b0;
                    if (pf_flags[FLAG_PERIODIC])
                    begin
                        mem_wr_addr      = best_idx_reg;
                        mem_wen.deadline = 1'b1;
                        if (pf_flags[FLAG_BLOCKED])
                        begin
                            mem_wdata.deadline       = 32'd0;
                            place_next[best_idx_reg] = PLACE_PARKED;
                        end
                        else
                        begin
                            mem_wdata.deadline = time_reg + best_iv_reg;
                        end
                        tgt_next   = best_idx_reg;
                        ret_next   = S_DS_SCAN;
                        state_next = S_GIVE;
                    end
                    else
                    begin
                        place_next[best_idx_reg] = PLACE_IDLE;
                        flags_next[best_idx_reg] = '0;
                        state_next               = S_DS_SCAN;
                        scan_start               = 1'b1;
                    end
                end
            end
            S_SL_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_SL_EMIT;
                end
            end
            S_SL_EMIT:
            begin
                if (out_can_load)
                begin
                    out_load     = 1'b1;
                    out_din.kind = KIND_SLEEP;
                    out_din.last = 1'b1;
                    if (!bv_reg)
                    begin
                        out_din.sleep_ms = idle_wait_reg;
                    end
                    else if (best_dl_reg <= time_reg)
                    begin
                        out_din.sleep_ms = 32'd0;
                    end
                    else
                    begin
                        out_din.sleep_ms = best_dl_reg - time_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Restart the sweep machinery on entry to a sweep
        if (scan_start)
        begin
            sc_next    = '0;
            chk_v_next = 1'b0;
            bv_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            time_reg      <= 32'd0;
            ord_cnt_reg   <= 8'd0;
            rn_cnt_reg    <= '0;
            sc_reg        <= '0;
            chk_v_reg     <= 1'b0;
            bv_reg        <= 1'b0;
            due_reg       <= '0;
            done_reg      <= '0;
            dev_en_reg    <= 1'b1;
            idle_wait_reg <= IDLE_WAIT_RESET;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                place_reg[i] <= PLACE_IDLE;
                flags_reg[i] <= 3'd0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            time_reg    <= time_next;
            ord_cnt_reg <= ord_cnt_next;
            rn_cnt_reg  <= rn_cnt_next;
            sc_reg      <= sc_next;
            chk_v_reg   <= chk_v_next;
            bv_reg      <= bv_next;
            due_reg     <= due_next;
            done_reg    <= done_next;
            place_reg   <= place_next;
            flags_reg   <= flags_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DEVICE_ENABLED: dev_en_reg    <= cfg_data[0];
                    CFG_IDLE_WAIT:      idle_wait_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg      <= tgt_next;
        chk_idx_reg  <= chk_idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        best_iv_reg  <= best_iv_next;
        best_ord_reg <= best_ord_next;
    end

endmodule

[hdl/dts_checker.sv]
`include "deadline_task_scheduler_assert.svh"

module dts_checker
    import dts_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [2:0]           cmd,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           kind,
    input logic [3:0]           slot,
    input logic [31:0]          sleep_ms,
    input logic                 last
);

    // Hold a stalled result unchanged
    `DTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(slot) && $stable(sleep_ms) && $stable(last))

    // Only the sleep report closes a run
    `DTS_ASSERT_SAME(a_last_report, out_valid, (kind == KIND_SLEEP) == last)

    // Dispatches carry no sleep time
    `DTS_ASSERT_SAME(a_dispatch_zero, out_valid && (kind != KIND_SLEEP), sleep_ms == 32'd0)

    // No command is taken while a run is still delivering
    `DTS_ASSERT_SAME(a_busy_mid_run, out_valid && !last, !in_ready)

    // A run leaves the block busy in the cycle after it is taken
    `DTS_ASSERT_NEXT(a_run_busy, in_valid && in_ready && (cmd == CMD_RUN), !in_ready)

endmodule

bind deadline_task_scheduler dts_checker u_dts_checker (.*);

[test/dispatch_checker.sv]
`timescale 1ns / 100ps

module dispatch_checker
    import dts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [2:0]           cmd,
    input  logic [3:0]           task_id,
    input  logic [31:0]          amount,
    input  logic                 enabled_only,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           kind,
    input  logic [3:0]           slot,
    input  logic [31:0]          sleep_ms,
    input  logic                 last,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam int NSLOTS = 16;

    // Shadow copy of the scheduler state
    bit          dev_on;
    bit [31:0]   idle_ms;
    bit [31:0]   now_ms;
    bit [31:0]   due_at   [NSLOTS];
    bit [31:0]   period   [NSLOTS];
    bit [1:0]    where_is [NSLOTS];
    bit [2:0]    flags    [NSLOTS];
    bit [7:0]    seq_no   [NSLOTS];
    int unsigned seq_next;

    result_t due_results[$];

    task automatic clear_shadow();
        dev_on   = 1'b1;
        idle_ms  = IDLE_WAIT_RESET;
        now_ms   = '0;
        seq_next = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            due_at[i]   = '0;
            period[i]   = '0;
            where_is[i] = PLACE_IDLE;
            flags[i]    = '0;
            seq_no[i]   = '0;
        end
    endtask

    // Compact the order numbers of live slots to 0..n-1
    task automatic compact_order();
        bit [7:0]    rank [NSLOTS];
        int unsigned live;
        int unsigned r;
        live = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            rank[i] = '0;
            if (where_is[i] == PLACE_IDLE)
                continue;
            live++;
            r = 0;
            for (int j = 0; j < NSLOTS; j++)
            begin
                if (j == i || where_is[j] == PLACE_IDLE)
                    continue;
                if (seq_no[j] < seq_no[i] || (seq_no[j] == seq_no[i] && j < i))
                    r++;
            end
            rank[i] = r[7:0];
        end
        for (int i = 0; i < NSLOTS; i++)
            if (where_is[i] != PLACE_IDLE)
                seq_no[i] = rank[i];
        seq_next = live;
    endtask

    task automatic stamp_order(int s);
        if (seq_next >= 255)
            compact_order();
        seq_no[s] = seq_next[7:0];
        seq_next  = (seq_next + 1) & 8'hFF;
    endtask

    task automatic arm_slot(int s, bit [31:0] when, bit periodic, bit enonly);
        bit [2:0] f;
        f = '0;
        f[FLAG_BLOCKED]  = flags[s][FLAG_BLOCKED];
        f[FLAG_PERIODIC] = periodic;
        f[FLAG_ENONLY]   = enonly;
        flags[s]    = f;
        due_at[s]   = when;
        where_is[s] = PLACE_QUEUED;
        stamp_order(s);
    endtask

    task automatic push_result(bit [1:0] k, bit [3:0] s, bit [31:0] ms, bit l);
        result_t r;
        r.kind     = k;
        r.slot     = s;
        r.sleep_ms = ms;
        r.last     = l;
        due_results.push_back(r);
    endtask

    task automatic predict_run();
        bit [NSLOTS-1:0] due;
        bit [31:0]       best;
        bit              any;
        bit [1:0]        k;
        bit [2:0]        f;
        int              pick;
        // Unpark slots no longer blocked, oldest first
        forever
        begin
            pick = -1;
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (where_is[i] != PLACE_PARKED || flags[i][FLAG_BLOCKED])
                    continue;
                if (pick < 0 || seq_no[i] < seq_no[pick])
                    pick = i;
            end
            if (pick < 0)
                break;
            due_at[pick]   = now_ms;
            where_is[pick] = PLACE_QUEUED;
            stamp_order(pick);
        end
        due = '0;
        for (int i = 0; i < NSLOTS; i++)
            if (where_is[i] == PLACE_QUEUED && now_ms >= due_at[i])
                due[i] = 1'b1;
        while (due != '0)
        begin
            pick = -1;
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (!due[i])
                    continue;
                if (pick < 0 || due_at[i] < due_at[pick] ||
                    (due_at[i] == due_at[pick] && seq_no[i] < seq_no[pick]))
                    pick = i;
            end
            due[pick] = 1'b0;
            f = flags[pick];
            if (f[FLAG_BLOCKED])
                k = KIND_PARKED;
            else if (dev_on || !f[FLAG_ENONLY])
                k = KIND_RUN;
            else
                k = KIND_SKIPPED;
            push_result(k, pick[3:0], '0, 1'b0);
            if (f[FLAG_PERIODIC])
            begin
                if (f[FLAG_BLOCKED])
                begin
                    due_at[pick]   = '0;
                    where_is[pick] = PLACE_PARKED;
                end
                else
                    due_at[pick] = now_ms + period[pick];
                stamp_order(pick);
            end
            else
            begin
                where_is[pick] = PLACE_IDLE;
                flags[pick]    = '0;
            end
        end
        any  = 1'b0;
        best = '0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (where_is[i] != PLACE_QUEUED)
                continue;
            if (!any || due_at[i] < best)
                best = due_at[i];
            any = 1'b1;
        end
        if (!any)
            push_result(KIND_SLEEP, '0, idle_ms, 1'b1);
        else if (best <= now_ms)
            push_result(KIND_SLEEP, '0, '0, 1'b1);
        else
            push_result(KIND_SLEEP, '0, best - now_ms, 1'b1);
    endtask

    task automatic predict_command(bit [2:0] c, int s, bit [31:0] a, bit e);
        case (c)
            CMD_ADVANCE:      now_ms = now_ms + a;
            CMD_RUN:          predict_run();
            CMD_ARM_ONCE:     arm_slot(s, now_ms + a, 1'b0, e);
            CMD_ARM_PERIODIC:
            begin
                period[s] = a;
                arm_slot(s, now_ms, 1'b1, e);
            end
            CMD_BLOCK:
                if (flags[s][FLAG_PERIODIC])
                    flags[s][FLAG_BLOCKED] = 1'b1;
            CMD_UNBLOCK:      flags[s][FLAG_BLOCKED] = 1'b0;
            default:          ;
        endcase
    endtask

    task automatic compare_result();
        result_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t: unexpected result kind=%0d slot=%0d sleep_ms=%0d last=%0d",
                     $time, kind, slot, sleep_ms, last);
            errors++;
            return;
        end
        want = due_results.pop_front();
        if (kind !== want.kind)
        begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
            errors++;
        end
        if (slot !== want.slot)
        begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, slot);
            errors++;
        end
        if (sleep_ms !== want.sleep_ms)
        begin
            $display("%0t: sleep_ms expected %0d actual %0d", $time, want.sleep_ms, sleep_ms);
            errors++;
        end
        if (last !== want.last)
        begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, last);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_shadow();
            due_results.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                compare_result();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DEVICE_ENABLED)
                    dev_on = cfg_data[0];
                else if (cfg_index == CFG_IDLE_WAIT)
                    idle_ms = cfg_data;
            end
            if (in_valid && in_ready)
                predict_command(cmd, int'(task_id), amount, enabled_only);
            pending = due_results.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import dts_pkg::*;

    // Command codes the block decodes as no-ops
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 400;   // covers a renumber pass after the last command

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [2:0]           cmd;
    logic [3:0]           task_id;
    logic [31:0]          amount;
    logic                 enabled_only;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           kind;
    logic [3:0]           slot;
    logic [31:0]          sleep_ms;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int errors;
    int pending;
    int cycles;
    int burst_left;
    int stall_phase;
    logic [15:0] stall_word;

    deadline_task_scheduler dut (.*);

    dispatch_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver stalls on a rotating pattern, refreshed now and then;
    // a quarter of the patterns never stall at all
    always @(posedge clk)
    begin
        out_ready   <= stall_word[stall_phase % 16];
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 == 96)
            stall_word <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
    end

    // Drive one command transaction; hold it until the block takes it.
    // Close the current burst with a gap of idle cycles first where due.
    task automatic send(logic [2:0] c, logic [3:0] id, logic [31:0] a, logic e);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        task_id      <= id;
        amount       <= a;
        enabled_only <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] wild_amount();
        case ($urandom_range(0, 3))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed bursts: arm a few slots, poke blocking, advance, run
    task automatic random_items(int count);
        int n;
        int k;
        logic [3:0] id;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++)
                begin
                    id = 4'($urandom_range(0, 15));
                    if ($urandom_range(0, 1))
                        send(CMD_ARM_ONCE, id, $urandom_range(0, 40),
                             1'($urandom_range(0, 1)));
                    else
                        send(CMD_ARM_PERIODIC, id, $urandom_range(1, 60),
                             1'($urandom_range(0, 1)));
                    n++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send(CMD_BLOCK, 4'($urandom_range(0, 15)), $urandom,
                         1'($urandom_range(0, 1)));
                    n++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send(CMD_UNBLOCK, 4'($urandom_range(0, 15)), $urandom,
                         1'($urandom_range(0, 1)));
                    n++;
                end
                send(CMD_ADVANCE, 4'($urandom), $urandom_range(0, 50),
                     1'($urandom_range(0, 1)));
                send(CMD_RUN, 4'($urandom), $urandom, 1'($urandom_range(0, 1)));
                n += 2;
            end
            else
            begin
                send(3'($urandom_range(0, 7)), 4'($urandom), wild_amount(),
                     1'($urandom_range(0, 1)));
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_ADVANCE;
        task_id      = '0;
        amount       = '0;
        enabled_only = 1'b0;
        out_ready    = 1'b1;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_DEVICE_ENABLED;
        cfg_data     = '0;
        cycles       = 0;
        burst_left   = 0;
        stall_phase  = 0;
        stall_word   = 16'hFFFF;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every command, the special cases
        send(CMD_RUN, 4'd0, 32'h0, 1'b0);                       // empty queue: idle wait
        send(CMD_ARM_ONCE, 4'd0, 32'h0, 1'b0);
        send(CMD_ARM_PERIODIC, 4'd1, 32'hFFFF_FFFF, 1'b1);
        send(CMD_ARM_ONCE, 4'd15, 32'hFFFF_FFFF, 1'b1);         // all-ones deadline
        send(CMD_SPARE_A, 4'd3, 32'hFFFF_FFFF, 1'b1);
        send(CMD_SPARE_B, 4'd15, 32'h0, 1'b0);
        send(CMD_BLOCK, 4'd0, 32'h0, 1'b0);                     // one-shot: ignored
        send(CMD_BLOCK, 4'd7, 32'h0, 1'b0);                     // idle slot: ignored
        send(CMD_BLOCK, 4'd1, 32'h0, 1'b0);
        send(CMD_RUN, 4'd0, 32'h0, 1'b0);                       // slot 1 parks
        send(CMD_ARM_PERIODIC, 4'd2, 32'd5, 1'b0);
        send(CMD_UNBLOCK, 4'd1, 32'h0, 1'b0);
        send(CMD_RUN, 4'd0, 32'h0, 1'b0);                       // slot 1 back, due now
        send(CMD_ARM_ONCE, 4'd2, 32'd3, 1'b1);                  // re-arm replaces
        send(CMD_ADVANCE, 4'd0, 32'hFFFF_FFFF, 1'b0);           // wrap
        send(CMD_RUN, 4'd0, 32'h0, 1'b0);
        send(CMD_ADVANCE, 4'd0, 32'd10, 1'b0);
        send(CMD_RUN, 4'd15, 32'hFFFF_FFFF, 1'b1);
        drain();

        // Sweep settings: disabled with zero wait, enabled with full wait, disabled with random wait, enabled with 1000
        write_reg(CFG_DEVICE_ENABLED, 32'd0);
        write_reg(CFG_IDLE_WAIT, 32'd0);
        random_items(115);
        drain();
        write_reg(CFG_DEVICE_ENABLED, 32'd1);
        write_reg(CFG_IDLE_WAIT, 32'hFFFF_FFFF);
        random_items(115);
        drain();
        write_reg(CFG_DEVICE_ENABLED, 32'hFFFF_FFFE);           // only bit 0 counts
        write_reg(CFG_IDLE_WAIT, $urandom);
        random_items(115);
        drain();
        write_reg(CFG_DEVICE_ENABLED, 32'hFFFF_FFFF);
        write_reg(CFG_IDLE_WAIT, 32'd1000);
        random_items(115);
        drain();

        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
